>>> hdl/tlq_pkg.sv
// Shared constants and types for the thick line quad expander.
package tlq_pkg;

    localparam int W_BITS = 12;
    localparam int INDEX_BITS = 16;
    localparam int CORNER_BITS = 2;

    typedef logic [W_BITS-1:0] width_t;
    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [CORNER_BITS-1:0] corner_t;

    localparam width_t OFFSET_RESET = 12'd16;
    localparam width_t OFFSET_MAX = 12'hFFF;
    localparam corner_t CORNER_LAST = 2'd3;
    localparam index_t INDEX_STEP = 16'd4;

endpackage

>>> hdl/tlq_front.sv
// Front end: takes segments, forms direction magnitudes and signs, and queues them.
module tlq_front import tlq_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic                         deq,
    output logic                         dvalid,
    output logic signed [COORD_BITS-1:0] d_sx,
    output logic signed [COORD_BITS-1:0] d_sy,
    output logic signed [COORD_BITS-1:0] d_ex,
    output logic signed [COORD_BITS-1:0] d_ey,
    output logic        [COORD_BITS-1:0] d_ax,
    output logic        [COORD_BITS-1:0] d_ay,
    output logic                         d_negx,
    output logic                         d_negy,
    output logic                         d_degen
);

    localparam int CB = COORD_BITS;

    logic signed [CB:0] dx;
    logic signed [CB:0] dy;
    logic [CB:0]        ndx;
    logic [CB:0]        ndy;
    logic [CB-1:0]      ax;
    logic [CB-1:0]      ay;
    logic               enq;

    logic signed [CB-1:0] q_sx_reg [2];
    logic signed [CB-1:0] q_sy_reg [2];
    logic signed [CB-1:0] q_ex_reg [2];
    logic signed [CB-1:0] q_ey_reg [2];
    logic [CB-1:0]        q_ax_reg [2];
    logic [CB-1:0]        q_ay_reg [2];
    logic                 q_negx_reg [2];
    logic                 q_negy_reg [2];
    logic                 q_degen_reg [2];

    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    always_comb
    begin
        dx  = $signed({end_x[CB-1], end_x}) - $signed({start_x[CB-1], start_x});
        dy  = $signed({end_y[CB-1], end_y}) - $signed({start_y[CB-1], start_y});
        ndx = -dx;
        ndy = -dy;
        ax  = dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
        ay  = dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];
    end

    assign full   = (cnt_reg == 2'd2);
    assign dvalid = (cnt_reg != 2'd0);
    assign enq    = push && !full;

    always_comb
    begin
        wr_ptr_next = enq ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (deq && dvalid) ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(enq) - 2'(deq && dvalid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_sx_reg[wr_ptr_reg]    <= start_x;
            q_sy_reg[wr_ptr_reg]    <= start_y;
            q_ex_reg[wr_ptr_reg]    <= end_x;
            q_ey_reg[wr_ptr_reg]    <= end_y;
            q_ax_reg[wr_ptr_reg]    <= ax;
            q_ay_reg[wr_ptr_reg]    <= ay;
            q_negx_reg[wr_ptr_reg]  <= dx[CB];
            q_negy_reg[wr_ptr_reg]  <= dy[CB];
            q_degen_reg[wr_ptr_reg] <= (dx == '0) && (dy == '0);
        end
    end

    assign d_sx    = q_sx_reg[rd_ptr_reg];
    assign d_sy    = q_sy_reg[rd_ptr_reg];
    assign d_ex    = q_ex_reg[rd_ptr_reg];
    assign d_ey    = q_ey_reg[rd_ptr_reg];
    assign d_ax    = q_ax_reg[rd_ptr_reg];
    assign d_ay    = q_ay_reg[rd_ptr_reg];
    assign d_negx  = q_negx_reg[rd_ptr_reg];
    assign d_negy  = q_negy_reg[rd_ptr_reg];
    assign d_degen = q_degen_reg[rd_ptr_reg];

endmodule

>>> hdl/tlq_back.sv
// Back end: offset search on a shared shift-add multiplier, then emits the four corners.
module tlq_back import tlq_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         dvalid,
    output logic                         deq,
    input  logic signed [COORD_BITS-1:0] d_sx,
    input  logic signed [COORD_BITS-1:0] d_sy,
    input  logic signed [COORD_BITS-1:0] d_ex,
    input  logic signed [COORD_BITS-1:0] d_ey,
    input  logic        [COORD_BITS-1:0] d_ax,
    input  logic        [COORD_BITS-1:0] d_ay,
    input  logic                         d_negx,
    input  logic                         d_negy,
    input  logic                         d_degen,
    input  width_t                       offset_width,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [COORD_BITS-1:0] vertex_x,
    output logic signed [COORD_BITS-1:0] vertex_y,
    output corner_t                      corner,
    output index_t                       base_index,
    output logic                         degenerate,
    output logic                         saturated,
    output logic                         last
);

    localparam int CB = COORD_BITS;
    localparam int PW = 2 * CB + 27;
    localparam int MB = (CB > 26) ? CB : 26;
    localparam int SW = ((CB > 13) ? CB : 13) + 2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_SQX  = 4'd2;
    localparam logic [3:0] S_SQY  = 4'd3;
    localparam logic [3:0] S_RX   = 4'd4;
    localparam logic [3:0] S_ITER = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_RY   = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    localparam logic signed [SW-1:0] C_TOP = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [SW-1:0] C_BOT = {{(SW-CB+1){1'b1}}, {(CB-1){1'b0}}};

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [3:0] ret_reg;
    logic [3:0] ret_next;
    corner_t    k_reg;
    corner_t    k_next;
    index_t     base_reg;
    index_t     base_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    logic signed [CB-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [CB-1:0] ex_reg, ex_next, ey_reg, ey_next;
    logic [CB-1:0]        ay_reg, ay_next;
    logic                 negx_reg, negx_next, negy_reg, negy_next;
    logic                 degen_reg, degen_next;
    logic [2*CB-1:0]      sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [2*CB:0]        s_reg, s_next;
    logic [PW-1:0]        rhs_reg, rhs_next;
    width_t               lo_reg, lo_next, hi_reg, hi_next, n_reg, n_next;
    width_t               ox_reg, ox_next, oy_reg, oy_next;
    logic                 comp_y_reg, comp_y_next;
    logic [PW-1:0]        ma_reg, ma_next, acc_reg, acc_next;
    logic [MB-1:0]        mb_reg, mb_next;

    logic signed [CB-1:0] vx_out_reg, vx_out_next, vy_out_reg, vy_out_next;
    corner_t              corner_out_reg, corner_out_next;
    index_t               base_out_reg, base_out_next;
    logic                 degen_out_reg, degen_out_next;
    logic                 sat_out_reg, sat_out_next;

    logic [PW-1:0]        part;
    logic [12:0]          mid_sum;
    width_t               mid;
    logic [12:0]          t;
    logic [25:0]          tt;
    logic [23:0]          wsq;
    logic [25:0]          w4;
    logic signed [SW-1:0] oxs, oys, px, py, vx, vy;
    logic                 sat_x, sat_y;
    logic                 load;

    always_comb
    begin
        part    = ma_reg * PW'(mb_reg[3:0]);
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + 13'd1;
        mid     = mid_sum[12:1];
        t       = {mid, 1'b0} - 13'd1;
        tt      = 26'(t) * 26'(t);
        wsq     = 24'(offset_width) * 24'(offset_width);
        w4      = {wsq, 2'b00};
    end

    always_comb
    begin
        oxs = negx_reg ? -SW'(ox_reg) : SW'(ox_reg);
        oys = negy_reg ? -SW'(oy_reg) : SW'(oy_reg);
        px  = k_reg[1] ? SW'(ex_reg) : SW'(sx_reg);
        py  = k_reg[1] ? SW'(ey_reg) : SW'(sy_reg);
        vx  = !k_reg[0] ? px - oys : px + oys;
        vy  = !k_reg[0] ? py + oxs : py - oxs;
        sat_x = (vx > C_TOP) || (vx < C_BOT);
        sat_y = (vy > C_TOP) || (vy < C_BOT);
    end

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        k_next          = k_reg;
        base_next       = base_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        ex_next         = ex_reg;
        ey_next         = ey_reg;
        ay_next         = ay_reg;
        negx_next       = negx_reg;
        negy_next       = negy_reg;
        degen_next      = degen_reg;
        sqx_next        = sqx_reg;
        sqy_next        = sqy_reg;
        s_next          = s_reg;
        rhs_next        = rhs_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        n_next          = n_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        comp_y_next     = comp_y_reg;
        ma_next         = ma_reg;
        mb_next         = mb_reg;
        acc_next        = acc_reg;
        deq             = 1'b0;
        load            = 1'b0;
        vx_out_next     = vx_out_reg;
        vy_out_next     = vy_out_reg;
        corner_out_next = corner_out_reg;
        base_out_next   = base_out_reg;
        degen_out_next  = degen_out_reg;
        sat_out_next    = sat_out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (dvalid)
                begin
                    deq        = 1'b1;
                    sx_next    = d_sx;
                    sy_next    = d_sy;
                    ex_next    = d_ex;
                    ey_next    = d_ey;
                    ay_next    = d_ay;
                    negx_next  = d_negx;
                    negy_next  = d_negy;
                    degen_next = d_degen;
                    k_next     = '0;
                    if (d_degen)
                    begin
                        ox_next    = '0;
                        oy_next    = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        ma_next    = PW'(d_ax);
                        mb_next    = MB'(d_ax);
                        acc_next   = '0;
                        ret_next   = S_SQX;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                acc_next = acc_reg + part;
                ma_next  = ma_reg << 4;
                mb_next  = mb_reg >> 4;
                if (mb_reg[MB-1:4] == '0)
                begin
                    state_next = ret_reg;
                end
            end
            S_SQX:
            begin
                sqx_next   = acc_reg[2*CB-1:0];
                ma_next    = PW'(ay_reg);
                mb_next    = MB'(ay_reg);
                acc_next   = '0;
                ret_next   = S_SQY;
                state_next = S_MUL;
            end
            S_SQY:
            begin
                sqy_next   = acc_reg[2*CB-1:0];
                s_next     = {1'b0, sqx_reg} + {1'b0, acc_reg[2*CB-1:0]};
                ma_next    = PW'(sqx_reg);
                mb_next    = MB'(w4);
                acc_next   = '0;
                ret_next   = S_RX;
                state_next = S_MUL;
            end
            S_RX:
            begin
                rhs_next    = acc_reg;
                lo_next     = '0;
                hi_next     = OFFSET_MAX;
                comp_y_next = 1'b0;
                state_next  = S_ITER;
            end
            S_ITER:
            begin
                if (lo_reg < hi_reg)
                begin
                    n_next     = mid;
                    ma_next    = PW'(s_reg);
                    mb_next    = MB'(tt);
                    acc_next   = '0;
                    ret_next   = S_CMP;
                    state_next = S_MUL;
                end
                else if (!comp_y_reg)
                begin
                    ox_next     = lo_reg;
                    comp_y_next = 1'b1;
                    ma_next     = PW'(sqy_reg);
                    mb_next     = MB'(w4);
                    acc_next    = '0;
                    ret_next    = S_RY;
                    state_next  = S_MUL;
                end
                else
                begin
                    oy_next    = lo_reg;
                    state_next = S_EMIT;
                end
            end
            S_CMP:
            begin
                if (acc_reg <= rhs_reg)
                begin
                    lo_next = n_reg;
                end
                else
                begin
                    hi_next = n_reg - 12'd1;
                end
                state_next = S_ITER;
            end
            S_RY:
            begin
                rhs_next   = acc_reg;
                lo_next    = '0;
                hi_next    = OFFSET_MAX;
                state_next = S_ITER;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || pop)
                begin
                    load            = 1'b1;
                    vx_out_next     = sat_x ? (vx > C_TOP ? C_TOP[CB-1:0] : C_BOT[CB-1:0])
                                            : vx[CB-1:0];
                    vy_out_next     = sat_y ? (vy > C_TOP ? C_TOP[CB-1:0] : C_BOT[CB-1:0])
                                            : vy[CB-1:0];
                    corner_out_next = k_reg;
                    base_out_next   = base_reg;
                    degen_out_next  = degen_reg;
                    sat_out_next    = sat_x || sat_y;
                    k_next          = k_reg + 2'd1;
                    if (k_reg == CORNER_LAST)
                    begin
                        base_next  = base_reg + INDEX_STEP;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = load || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            k_reg         <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            k_reg         <= k_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        ex_reg         <= ex_next;
        ey_reg         <= ey_next;
        ay_reg         <= ay_next;
        negx_reg       <= negx_next;
        negy_reg       <= negy_next;
        degen_reg      <= degen_next;
        sqx_reg        <= sqx_next;
        sqy_reg        <= sqy_next;
        s_reg          <= s_next;
        rhs_reg        <= rhs_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        n_reg          <= n_next;
        ox_reg         <= ox_next;
        oy_reg         <= oy_next;
        comp_y_reg     <= comp_y_next;
        ma_reg         <= ma_next;
        mb_reg         <= mb_next;
        acc_reg        <= acc_next;
        vx_out_reg     <= vx_out_next;
        vy_out_reg     <= vy_out_next;
        corner_out_reg <= corner_out_next;
        base_out_reg   <= base_out_next;
        degen_out_reg  <= degen_out_next;
        sat_out_reg    <= sat_out_next;
    end

    assign empty      = !out_valid_reg;
    assign vertex_x   = vx_out_reg;
    assign vertex_y   = vy_out_reg;
    assign corner     = corner_out_reg;
    assign base_index = base_out_reg;
    assign degenerate = degen_out_reg;
    assign saturated  = sat_out_reg;
    assign last       = (corner_out_reg == CORNER_LAST);

endmodule

>>> hdl/thick_line_quad_expander.sv
// Top level of the thick line quad expander: segment in, four quad corners out.
// Usage: push a segment (start_x, start_y, end_x, end_y) while full is low; each
// segment yields four vertex beats in corner order start-left, start-right,
// end-left, end-right, read while empty is low and taken with pop.
// Every beat carries the segment's base index, which advances by four per
// segment and wraps at 65536, so the triangles are base+0,1,2 and base+2,1,3.
// cfg_we writes offset_width (unsigned Q8.4) from cfg_wdata; write it only
// while the block is idle.
// A segment of nonzero length goes through the offset search on the shift-add
// multiplier, which retires four bits per cycle: a dequeue step, two squares,
// two right-hand products, and per component twelve trial compares plus one
// closing step. The four corners then leave one per cycle while the receiver
// keeps taking them with pop.
// A zero-length segment skips the search.
// A two-entry queue in front takes new segments while the back end works.
// When the receiver stalls, the held vertex stays on the ports and the back
// end waits; the front queue fills and raises full.
// Reset clears the queues, the base index and sets offset_width to 1.0.
module thick_line_quad_expander import tlq_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic                         cfg_we,
    input  width_t                       cfg_wdata,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [COORD_BITS-1:0] vertex_x,
    output logic signed [COORD_BITS-1:0] vertex_y,
    output corner_t                      corner,
    output index_t                       base_index,
    output logic                         degenerate,
    output logic                         saturated,
    output logic                         last
);

    width_t offset_width_reg;
    width_t offset_width_next;

    logic                         dvalid;
    logic                         deq;
    logic signed [COORD_BITS-1:0] d_sx, d_sy, d_ex, d_ey;
    logic        [COORD_BITS-1:0] d_ax, d_ay;
    logic                         d_negx, d_negy, d_degen;

    assign offset_width_next = cfg_we ? cfg_wdata : offset_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_width_reg <= OFFSET_RESET;
        end
        else
        begin
            offset_width_reg <= offset_width_next;
        end
    end

    tlq_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .deq     (deq),
        .dvalid  (dvalid),
        .d_sx    (d_sx),
        .d_sy    (d_sy),
        .d_ex    (d_ex),
        .d_ey    (d_ey),
        .d_ax    (d_ax),
        .d_ay    (d_ay),
        .d_negx  (d_negx),
        .d_negy  (d_negy),
        .d_degen (d_degen)
    );

    tlq_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .dvalid       (dvalid),
        .deq          (deq),
        .d_sx         (d_sx),
        .d_sy         (d_sy),
        .d_ex         (d_ex),
        .d_ey         (d_ey),
        .d_ax         (d_ax),
        .d_ay         (d_ay),
        .d_negx       (d_negx),
        .d_negy       (d_negy),
        .d_degen      (d_degen),
        .offset_width (offset_width_reg),
        .empty        (empty),
        .pop          (pop),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .corner       (corner),
        .base_index   (base_index),
        .degenerate   (degenerate),
        .saturated    (saturated),
        .last         (last)
    );

    a_deq_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        deq |-> dvalid)
        else $error("back end dequeued from an empty front queue");

    a_full_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> dvalid)
        else $error("front queue full without a valid entry");

    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last) ##1 !empty |-> corner == 2'($past(corner, 1) + 2'd1))
        else $error("corners of a segment left out of order");

    a_base_within_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last) ##1 !empty |-> base_index == $past(base_index, 1))
        else $error("base index changed within a segment");

endmodule
